FILE: src/vt_escape_sequence_parser_defines.svh
// ----------------------------------------------------------------------------
// vt_escape_sequence_parser_defines
// Assertion helpers for the escape-sequence parser checker.
// ----------------------------------------------------------------------------
`ifndef VT_ESCAPE_SEQUENCE_PARSER_DEFINES_SVH
`define VT_ESCAPE_SEQUENCE_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define VTP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vtp: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define VTP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vtp: next-cycle check failed");

`endif

FILE: src/vtp_pkg.sv
// ----------------------------------------------------------------------------
// vtp_pkg
// Codes and types shared by the escape-sequence parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package vtp_pkg;

   localparam int CHAR_W  = 21;
   localparam int KIND_W  = 4;
   localparam int STATE_W = 4;
   localparam int SLOTS   = 3;

   // parser states
   localparam logic [STATE_W-1:0] ST_GROUND       = 4'd0;
   localparam logic [STATE_W-1:0] ST_ESCAPE       = 4'd1;
   localparam logic [STATE_W-1:0] ST_ESC_INTER    = 4'd2;
   localparam logic [STATE_W-1:0] ST_CSI_ENTRY    = 4'd3;
   localparam logic [STATE_W-1:0] ST_CSI_PARAM    = 4'd4;
   localparam logic [STATE_W-1:0] ST_CSI_INTER    = 4'd5;
   localparam logic [STATE_W-1:0] ST_CSI_IGNORE   = 4'd6;
   localparam logic [STATE_W-1:0] ST_DCS_ENTRY    = 4'd7;
   localparam logic [STATE_W-1:0] ST_DCS_PARAM    = 4'd8;
   localparam logic [STATE_W-1:0] ST_DCS_INTER    = 4'd9;
   localparam logic [STATE_W-1:0] ST_DCS_PASS     = 4'd10;
   localparam logic [STATE_W-1:0] ST_DCS_IGNORE   = 4'd11;
   localparam logic [STATE_W-1:0] ST_OSC_STRING   = 4'd12;
   localparam logic [STATE_W-1:0] ST_SOS_STRING   = 4'd13;

   // action codes
   localparam logic [KIND_W-1:0] ACT_IGNORE    = 4'd0;
   localparam logic [KIND_W-1:0] ACT_EXECUTE   = 4'd1;
   localparam logic [KIND_W-1:0] ACT_PRINT     = 4'd2;
   localparam logic [KIND_W-1:0] ACT_COLLECT   = 4'd3;
   localparam logic [KIND_W-1:0] ACT_PARAM     = 4'd4;
   localparam logic [KIND_W-1:0] ACT_ESC_DISP  = 4'd5;
   localparam logic [KIND_W-1:0] ACT_CSI_DISP  = 4'd6;
   localparam logic [KIND_W-1:0] ACT_CLEAR     = 4'd7;
   localparam logic [KIND_W-1:0] ACT_HOOK      = 4'd8;
   localparam logic [KIND_W-1:0] ACT_PUT       = 4'd9;
   localparam logic [KIND_W-1:0] ACT_UNHOOK    = 4'd10;
   localparam logic [KIND_W-1:0] ACT_OSC_START = 4'd11;
   localparam logic [KIND_W-1:0] ACT_OSC_PUT   = 4'd12;
   localparam logic [KIND_W-1:0] ACT_OSC_END   = 4'd13;

   // all results caused by one request
   typedef struct packed {
      logic [SLOTS-1:0][KIND_W-1:0] kind;
      logic [SLOTS-1:0]             attached;
      logic [CHAR_W-1:0]            code;
      logic [STATE_W-1:0]           state_now;
      logic [1:0]                   count;
   } run_type;

endpackage

`default_nettype wire

FILE: src/vt_escape_sequence_parser.sv
// A VT500-style escape-sequence parser: each request carries one code point,
// which is registered, classified against the current parser state and turned
// into one to three results (exit action, the character's own action, enter
// action), delivered one per cycle while the result port is not stalled, with
// the last flagged. A single-result request passes at one per cycle when not
// stalled; one with more results holds the result register until its last is
// taken. A request reaches the port via the request and result registers.
// ----------------------------------------------------------------------------
// vt_escape_sequence_parser
// Top level: request register, parser state register, decode and results.
// ----------------------------------------------------------------------------
`default_nettype none

module vt_escape_sequence_parser (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [vtp_pkg::CHAR_W-1:0]  req_char_code,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [vtp_pkg::KIND_W-1:0]       rsp_action_kind,
   output logic [vtp_pkg::CHAR_W-1:0]       rsp_action_char,
   output logic                             rsp_char_attached,
   output logic [vtp_pkg::STATE_W-1:0]      rsp_parser_state_now,
   output logic                             rsp_last_of_run
);
   import vtp_pkg::*;

   logic               in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0]  in_char_ff;
   logic [STATE_W-1:0] state_ff, state_in;
   logic               run_free;
   logic               in_move;
   logic               req_take;
   run_type            run;

   assign in_move   = in_valid_ff && run_free;
   assign req_stall = in_valid_ff && !run_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in = req_take ? 1'b1 : (in_move ? 1'b0 : in_valid_ff);
   assign state_in    = in_move ? run.state_now : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= ST_GROUND;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) in_char_ff <= req_char_code;
   end

   vtp_decode u_decode (
      .state     (state_ff),
      .char_code (in_char_ff),
      .run       (run)
   );

   vtp_result_seq u_result (
      .clock                (clock),
      .reset                (reset),
      .load                 (in_move),
      .run                  (run),
      .run_free             (run_free),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_action_kind      (rsp_action_kind),
      .rsp_action_char      (rsp_action_char),
      .rsp_char_attached    (rsp_char_attached),
      .rsp_parser_state_now (rsp_parser_state_now),
      .rsp_last_of_run      (rsp_last_of_run)
   );

endmodule

`default_nettype wire

FILE: src/vtp_decode.sv
// ----------------------------------------------------------------------------
// vtp_decode
// Classifies one character against the current state and lists its actions.
// ----------------------------------------------------------------------------
`default_nettype none

module vtp_decode (
   input  wire logic [vtp_pkg::STATE_W-1:0] state,
   input  wire logic [vtp_pkg::CHAR_W-1:0]  char_code,
   output vtp_pkg::run_type                 run
);
   import vtp_pkg::*;

   logic [7:0]         raw8;
   logic               big;
   logic [7:0]         cc;
   logic               c0x, par, inter, fin;
   logic               any_hit;
   logic [STATE_W-1:0] any_next;
   logic [KIND_W-1:0]  any_act;
   logic               st_hit;
   logic [STATE_W-1:0] st_next;
   logic [KIND_W-1:0]  st_act;
   logic               has_next;
   logic [STATE_W-1:0] nxt;
   logic [KIND_W-1:0]  act;
   logic [KIND_W-1:0]  exit_kind, enter_kind;
   logic [1:0]         n;

   function automatic logic in_rng(input logic [7:0] c, input logic [7:0] lo,
                                   input logic [7:0] hi);
      in_rng = (c >= lo) && (c <= hi);
   endfunction

   // anywhere rules on the raw code point
   always_comb begin
      raw8     = char_code[7:0];
      big      = |char_code[CHAR_W-1:8];
      any_hit  = 1'b0;
      any_next = ST_GROUND;
      any_act  = ACT_IGNORE;
      if (!big) begin
         if (raw8 == 8'h18 || raw8 == 8'h1A || in_rng(raw8, 8'h80, 8'h8F) ||
             in_rng(raw8, 8'h91, 8'h97) || raw8 == 8'h99 || raw8 == 8'h9A) begin
            any_hit = 1'b1;
            any_act = ACT_EXECUTE;
         end else if (raw8 == 8'h9C) begin
            any_hit = 1'b1;
         end else if (raw8 == 8'h1B) begin
            any_hit  = 1'b1;
            any_next = ST_ESCAPE;
         end else if (raw8 == 8'h98 || raw8 == 8'h9E || raw8 == 8'h9F) begin
            any_hit  = 1'b1;
            any_next = ST_SOS_STRING;
         end else if (raw8 == 8'h90) begin
            any_hit  = 1'b1;
            any_next = ST_DCS_ENTRY;
         end else if (raw8 == 8'h9D) begin
            any_hit  = 1'b1;
            any_next = ST_OSC_STRING;
         end else if (raw8 == 8'h9B) begin
            any_hit  = 1'b1;
            any_next = ST_CSI_ENTRY;
         end
      end
   end

   // per-state rules; code points from 0xA0 up fold to 'A'
   always_comb begin
      cc      = (big || raw8 >= 8'hA0) ? 8'h41 : raw8;
      c0x     = (cc <= 8'h17) || (cc == 8'h19) || in_rng(cc, 8'h1C, 8'h1F);
      par     = in_rng(cc, 8'h30, 8'h39) || (cc == 8'h3B);
      inter   = in_rng(cc, 8'h20, 8'h2F);
      fin     = in_rng(cc, 8'h40, 8'h7E);
      st_hit  = 1'b0;
      st_next = ST_GROUND;
      st_act  = ACT_IGNORE;
      case (state)
         ST_ESCAPE: begin
            if (c0x) st_act = ACT_EXECUTE;
            else if (inter) begin
               st_act = ACT_COLLECT; st_hit = 1'b1; st_next = ST_ESC_INTER;
            end else if (cc == 8'h5B) begin
               st_hit = 1'b1; st_next = ST_CSI_ENTRY;
            end else if (cc == 8'h5D) begin
               st_hit = 1'b1; st_next = ST_OSC_STRING;
            end else if (cc == 8'h50) begin
               st_hit = 1'b1; st_next = ST_DCS_ENTRY;
            end else if (cc == 8'h58 || cc == 8'h5E || cc == 8'h5F) begin
               st_hit = 1'b1; st_next = ST_SOS_STRING;
            end else if (in_rng(cc, 8'h30, 8'h7E)) begin
               st_act = ACT_ESC_DISP; st_hit = 1'b1;
            end
         end
         ST_ESC_INTER: begin
            if (c0x) st_act = ACT_EXECUTE;
            else if (inter) st_act = ACT_COLLECT;
            else if (in_rng(cc, 8'h30, 8'h7E)) begin
               st_act = ACT_ESC_DISP; st_hit = 1'b1;
            end
         end
         ST_CSI_ENTRY: begin
            if (c0x) st_act = ACT_EXECUTE;
            else if (fin) begin
               st_act = ACT_CSI_DISP; st_hit = 1'b1;
            end else if (par) begin
               st_act = ACT_PARAM; st_hit = 1'b1; st_next = ST_CSI_PARAM;
            end else if (in_rng(cc, 8'h3C, 8'h3F)) begin
               st_act = ACT_COLLECT; st_hit = 1'b1; st_next = ST_CSI_PARAM;
            end else if (cc == 8'h3A) begin
               st_hit = 1'b1; st_next = ST_CSI_IGNORE;
            end else if (inter) begin
               st_act = ACT_COLLECT; st_hit = 1'b1; st_next = ST_CSI_INTER;
            end
         end
         ST_CSI_PARAM: begin
            if (c0x) st_act = ACT_EXECUTE;
            else if (par) st_act = ACT_PARAM;
            else if (cc == 8'h3A || in_rng(cc, 8'h3C, 8'h3F)) begin
               st_hit = 1'b1; st_next = ST_CSI_IGNORE;
            end else if (inter) begin
               st_act = ACT_COLLECT; st_hit = 1'b1; st_next = ST_CSI_INTER;
            end else if (fin) begin
               st_act = ACT_CSI_DISP; st_hit = 1'b1;
            end
         end
         ST_CSI_INTER: begin
            if (c0x) st_act = ACT_EXECUTE;
            else if (inter) st_act = ACT_COLLECT;
            else if (fin) begin
               st_act = ACT_CSI_DISP; st_hit = 1'b1;
            end else if (in_rng(cc, 8'h30, 8'h3F)) begin
               st_hit = 1'b1; st_next = ST_CSI_IGNORE;
            end
         end
         ST_CSI_IGNORE: begin
            if (c0x) st_act = ACT_EXECUTE;
            else if (fin) st_hit = 1'b1;
         end
         ST_DCS_ENTRY: begin
            if (inter) begin
               st_act = ACT_COLLECT; st_hit = 1'b1; st_next = ST_DCS_INTER;
            end else if (cc == 8'h3A) begin
               st_hit = 1'b1; st_next = ST_DCS_IGNORE;
            end else if (par) begin
               st_act = ACT_PARAM; st_hit = 1'b1; st_next = ST_DCS_PARAM;
            end else if (in_rng(cc, 8'h3C, 8'h3F)) begin
               st_act = ACT_COLLECT; st_hit = 1'b1; st_next = ST_DCS_PARAM;
            end else if (fin) begin
               st_hit = 1'b1; st_next = ST_DCS_PASS;
            end
         end
         ST_DCS_PARAM: begin
            if (par) st_act = ACT_PARAM;
            else if (cc == 8'h3A || in_rng(cc, 8'h3C, 8'h3F)) begin
               st_hit = 1'b1; st_next = ST_DCS_IGNORE;
            end else if (inter) begin
               st_act = ACT_COLLECT; st_hit = 1'b1; st_next = ST_DCS_INTER;
            end else if (fin) begin
               st_hit = 1'b1; st_next = ST_DCS_PASS;
            end
         end
         ST_DCS_INTER: begin
            if (inter) st_act = ACT_COLLECT;
            else if (fin) begin
               st_hit = 1'b1; st_next = ST_DCS_PASS;
            end else if (in_rng(cc, 8'h30, 8'h3F)) begin
               st_hit = 1'b1; st_next = ST_DCS_IGNORE;
            end
         end
         ST_DCS_PASS: begin
            if (c0x || in_rng(cc, 8'h20, 8'h7E)) st_act = ACT_PUT;
            else if (cc == 8'h9C) st_hit = 1'b1;
         end
         ST_DCS_IGNORE, ST_SOS_STRING: begin
            if (cc == 8'h9C) st_hit = 1'b1;
         end
         ST_OSC_STRING: begin
            if (in_rng(cc, 8'h20, 8'h7F)) st_act = ACT_OSC_PUT;
            else if (cc == 8'h9C || cc == 8'h07) st_hit = 1'b1;
         end
         default: begin
            // ground, and any stray code
            if (c0x) st_act = ACT_EXECUTE;
            else if (in_rng(cc, 8'h20, 8'h7F) || in_rng(cc, 8'hA0, 8'hFF))
               st_act = ACT_PRINT;
         end
      endcase
   end

   // order the actions: exit, transition, enter
   always_comb begin
      has_next = any_hit || st_hit;
      nxt      = any_hit ? any_next : st_next;
      act      = any_hit ? any_act  : st_act;

      case (state)
         ST_DCS_PASS:   exit_kind = ACT_UNHOOK;
         ST_OSC_STRING: exit_kind = ACT_OSC_END;
         default:       exit_kind = ACT_IGNORE;
      endcase
      case (nxt)
         ST_ESCAPE, ST_CSI_ENTRY, ST_DCS_ENTRY: enter_kind = ACT_CLEAR;
         ST_DCS_PASS:                           enter_kind = ACT_HOOK;
         ST_OSC_STRING:                         enter_kind = ACT_OSC_START;
         default:                               enter_kind = ACT_IGNORE;
      endcase

      run.kind     = '0;
      run.attached = '0;
      n            = 2'd0;
      if (has_next && exit_kind != ACT_IGNORE) begin
         run.kind[n] = exit_kind;
         n           = n + 2'd1;
      end
      if (act != ACT_IGNORE) begin
         run.kind[n]     = act;
         run.attached[n] = 1'b1;
         n               = n + 2'd1;
      end
      if (has_next && enter_kind != ACT_IGNORE) begin
         run.kind[n] = enter_kind;
         n           = n + 2'd1;
      end
      if (n == 2'd0) begin
         // nothing to do: report a single ignore carrying the character
         run.kind[0]     = ACT_IGNORE;
         run.attached[0] = 1'b1;
         n               = 2'd1;
      end
      run.count     = n;
      run.code      = char_code;
      run.state_now = has_next ? nxt : state;
   end

endmodule

`default_nettype wire

FILE: src/vtp_result_seq.sv
// ----------------------------------------------------------------------------
// vtp_result_seq
// Result register; gives a request's actions one per cycle while not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module vtp_result_seq (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        load,
   input  wire vtp_pkg::run_type            run,
   output logic                             run_free,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [vtp_pkg::KIND_W-1:0]       rsp_action_kind,
   output logic [vtp_pkg::CHAR_W-1:0]       rsp_action_char,
   output logic                             rsp_char_attached,
   output logic [vtp_pkg::STATE_W-1:0]      rsp_parser_state_now,
   output logic                             rsp_last_of_run
);
   import vtp_pkg::*;

   run_type    run_ff;
   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       last;
   logic       take;

   assign last     = (idx_ff == (run_ff.count - 2'd1));
   assign take     = valid_ff && !rsp_stall;
   assign run_free = !valid_ff || (take && last);

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = 2'd0;
      end else if (take) begin
         // advance within the run, drop the run after its last result
         if (last) valid_in = 1'b0;
         else      idx_in   = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) run_ff <= run;
   end

   assign rsp_valid            = valid_ff;
   assign rsp_action_kind      = run_ff.kind[idx_ff];
   assign rsp_char_attached    = run_ff.attached[idx_ff];
   assign rsp_action_char      = run_ff.attached[idx_ff] ? run_ff.code : '0;
   assign rsp_parser_state_now = run_ff.state_now;
   assign rsp_last_of_run      = last;

endmodule

`default_nettype wire

FILE: src/vtp_checker.sv
// ----------------------------------------------------------------------------
// vtp_checker
// Port-level checks on the result stream of the escape-sequence parser.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vt_escape_sequence_parser_defines.svh"

module vtp_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_stall,
   input wire logic [vtp_pkg::KIND_W-1:0]  rsp_action_kind,
   input wire logic [vtp_pkg::CHAR_W-1:0]  rsp_action_char,
   input wire logic                        rsp_char_attached,
   input wire logic [vtp_pkg::STATE_W-1:0] rsp_parser_state_now,
   input wire logic                        rsp_last_of_run
);
   import vtp_pkg::*;

   // a stalled result holds
   `VTP_ASSERT_NEXT(a_hold_kind, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_action_kind))

   // exit and enter actions carry no character and are only the framing kinds
   `VTP_ASSERT_NOW(a_frame_kind, rsp_valid && !rsp_char_attached, rsp_action_char == '0 && (rsp_action_kind == ACT_CLEAR || rsp_action_kind == ACT_HOOK || rsp_action_kind == ACT_UNHOOK || rsp_action_kind == ACT_OSC_START || rsp_action_kind == ACT_OSC_END))

   // a run continues without a gap
   `VTP_ASSERT_NEXT(a_run_cont, rsp_valid && !rsp_stall && !rsp_last_of_run, rsp_valid)

   // all results of one run report the same state
   `VTP_ASSERT_NEXT(a_run_state, rsp_valid && !rsp_stall && !rsp_last_of_run, $stable(rsp_parser_state_now))

endmodule

bind vt_escape_sequence_parser vtp_checker u_vtp_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_action_kind      (rsp_action_kind),
   .rsp_action_char      (rsp_action_char),
   .rsp_char_attached    (rsp_char_attached),
   .rsp_parser_state_now (rsp_parser_state_now),
   .rsp_last_of_run      (rsp_last_of_run)
);

`default_nettype wire
